>>> sv/spq_pkg.sv
package spq_pkg;

    localparam int MAX_ENTRIES_DEF = 8;
    localparam logic [3:0] CAPACITY_RESET = 4'd5;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] element;
        logic [15:0]        priority_req;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_element;
        logic [15:0]        out_priority;
        logic [1:0]         status;
        logic [3:0]         occupancy;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] elem;
        logic [15:0]        prio;
    } t_entry;

    // per-cell control from the top level
    typedef struct packed {
        logic enq;      // enqueue happens this cycle
        logic deq;      // dequeue happens this cycle
        logic live;     // cell holds a live entry
        logic at_tail;  // first free cell
    } t_cell_ctl;

endpackage

>>> sv/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  logic      i_left_gt,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_gt
);

    t_entry r_entry;
    t_entry n_entry;

    // strictly greater keeps equal priorities in arrival order
    assign o_gt = i_ctl.live && (r_entry.prio > i_new.prio);

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.enq) begin
            priority if (i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt || i_ctl.at_tail) begin
                n_entry = i_new;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

>>> sv/sorted_priority_queue.sv
// Channel   Direction  Handshake                  Payload
// in        to block   i_in_valid / o_in_ready    i_in_word  (t_in_word)
// out       from block o_out_valid / i_out_ready  o_out_word (t_out_word)
// cfg       to block   i_cfg_valid / o_cfg_ready  i_cfg_data (capacity)
//
// One word per cycle: every cell compares its priority with the new word in
// parallel, so an enqueue or dequeue finishes in the cycle it is accepted.
// The result sits in one output register; a word is accepted while that
// register is empty or being taken, so a stalled output holds the input.
// Reset (synchronous, active low) clears the count, the output valid and
// sets capacity to 5; cell contents are not reset and need no clearing.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [3:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);  // count width
    localparam int LW = CW + 4;                   // compare width

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [3:0]    r_cap;
    logic          r_out_valid;
    t_out_word     r_out_word;
    t_out_word     n_out_word;

    logic [LW-1:0] limit;
    logic          full;
    logic          accept;
    logic          enq_do;
    logic          deq_do;
    t_entry        new_entry;

    t_entry        cell_entry [MAX_ENTRIES];
    logic          cell_gt    [MAX_ENTRIES];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;

    // capacity saturates at the number of cells
    assign limit = (LW'(r_cap) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(r_cap);
    assign full  = LW'(r_cnt) >= limit;

    assign enq_do = accept && (i_in_word.mode == MODE_ENQ) && !full;
    assign deq_do = accept && (i_in_word.mode == MODE_DEQ) && (r_cnt != '0);

    assign new_entry.elem = i_in_word.element;
    assign new_entry.prio = i_in_word.priority_req;

    // row of cells, head in cell 0
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        t_cell_ctl ctl;
        t_entry    left;
        t_entry    right;
        logic      left_gt;

        assign ctl.enq     = enq_do;
        assign ctl.deq     = deq_do;
        assign ctl.live    = CW'(g) < r_cnt;
        assign ctl.at_tail = CW'(g) == r_cnt;

        if (g == 0) begin : g_head
            assign left    = new_entry;
            assign left_gt = 1'b0;
        end else begin : g_mid
            assign left    = cell_entry[g-1];
            assign left_gt = cell_gt[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_last
            assign right = cell_entry[g];
        end else begin : g_body
            assign right = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_new     (new_entry),
            .i_left    (left),
            .i_left_gt (left_gt),
            .i_right   (right),
            .o_entry   (cell_entry[g]),
            .o_gt      (cell_gt[g])
        );
    end

    always_comb begin
        n_cnt = r_cnt;
        if (enq_do) begin
            n_cnt = r_cnt + CW'(1);
        end else if (deq_do) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_comb begin
        n_out_word              = '0;
        n_out_word.occupancy    = 4'(n_cnt);
        priority if (enq_do) begin
            n_out_word.status = ST_ENQUEUED;
        end else if (deq_do) begin
            n_out_word.status       = ST_DEQUEUED;
            n_out_word.out_element  = cell_entry[0].elem;
            n_out_word.out_priority = cell_entry[0].prio;
        end else if (i_in_word.mode == MODE_ENQ) begin
            n_out_word.status = ST_FULL;
        end else begin
            n_out_word.status = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_cap       <= CAPACITY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_cnt <= n_cnt;
            end
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> sv/spq_checker.sv
module spq_checker
    import spq_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_EMPTY) |-> o_out_word.occupancy == 4'd0)
        else $error("empty report with live entries");

    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != ST_DEQUEUED)
        |-> (o_out_word.out_element == '0) && (o_out_word.out_priority == '0))
        else $error("data on a non-dequeue result");

    a_enq_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_ENQUEUED)
        |-> (MAX_ENTRIES > 15) || (o_out_word.occupancy != 4'd0))
        else $error("enqueue left queue empty");

endmodule

bind sorted_priority_queue spq_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps

// Checks sorted_priority_queue against a behavioral copy of the queue.
// Each request word is predicted when the block accepts it. Each result word
// is compared with the oldest prediction still waiting.
module testbench;
    import spq_pkg::*;

    localparam int NUM_SLOTS    = MAX_ENTRIES_DEF;
    localparam int RANDOM_WORDS = 1200;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int TAIL_CYCLES  = 8;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       i_out_ready = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [3:0] i_cfg_data  = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_word  o_out_word;
    logic       o_cfg_ready;

    sorted_priority_queue i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow queue: sorted slots, live count and the capacity register.
    // ------------------------------------------------------------------
    t_entry      slots [NUM_SLOTS];
    int unsigned live_entries = 0;
    logic [3:0]  cap_now      = CAPACITY_RESET;

    t_out_word   pending_results [$];   // predicted result words, oldest first
    t_out_word   want_word;

    int errors      = 0;
    int n_stored    = 0;
    int n_dropped   = 0;
    int n_dequeued  = 0;
    int n_empty     = 0;
    int n_cap_write = 0;

    // sender burst state
    int unsigned burst_left = 0;
    int unsigned gap_len;

    // receiver stall pattern state
    int unsigned stall_kind = 0;
    int unsigned stall_left = 0;
    logic        stall_phase = 1'b0;

    int unsigned quiet_cycles = 0;

    // One step of the queue: returns the result word, updates the shadow state.
    function automatic t_out_word sorted_queue_step(t_in_word w);
        t_out_word   r;
        int unsigned lim;
        int          pos;
        r   = '0;
        // capacity above the slot count saturates
        lim = (cap_now > NUM_SLOTS) ? NUM_SLOTS : cap_now;
        if (w.mode == MODE_ENQ) begin
            if (live_entries >= lim) begin
                r.status = ST_FULL;
                n_dropped++;
            end else begin
                // new entry goes behind every entry with priority <= its own
                pos = live_entries;
                while (pos > 0 && slots[pos-1].prio > w.priority_req) begin
                    slots[pos] = slots[pos-1];
                    pos--;
                end
                slots[pos].elem = w.element;
                slots[pos].prio = w.priority_req;
                live_entries++;
                r.status = ST_ENQUEUED;
                n_stored++;
            end
        end else begin
            if (live_entries == 0) begin
                r.status = ST_EMPTY;
                n_empty++;
            end else begin
                r.out_element  = slots[0].elem;
                r.out_priority = slots[0].prio;
                for (int i = 1; i < live_entries; i++)
                    slots[i-1] = slots[i];
                live_entries--;
                r.status = ST_DEQUEUED;
                n_dequeued++;
            end
        end
        r.occupancy = 4'(live_entries);
        return r;
    endfunction

    function automatic t_in_word make_word(logic m, logic [31:0] e, logic [15:0] p);
        t_in_word w;
        w.mode         = m;
        w.element      = e;
        w.priority_req = p;
        return w;
    endfunction

    // Random request; enq_pct biases toward filling or draining.
    function automatic t_in_word random_request(int unsigned enq_pct);
        t_in_word w;
        w.mode = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(3))
                    0: w.element = 32'h8000_0000;
                    1: w.element = 32'h7fff_ffff;
                    2: w.element = 32'h0000_0000;
                    default: w.element = 32'hffff_ffff;
                endcase
            end
            1:       w.element = $urandom_range(15);
            default: w.element = $urandom;
        endcase
        // narrow priorities make ties common, so arrival order gets exercised
        case ($urandom_range(4))
            0:       w.priority_req = $urandom_range(1) ? 16'hffff : 16'h0000;
            1, 2:    w.priority_req = 16'($urandom_range(3));
            default: w.priority_req = 16'($urandom_range(16'hffff));
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driving. Every task starts and ends at a falling edge.
    // ------------------------------------------------------------------

    // Send one request word; bursts of random length with random gaps.
    task automatic push_request(t_in_word w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_len    = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap_len) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        pending_results.push_back(sorted_queue_step(w));
    endtask

    // Capacity changes only with no result outstanding.
    task automatic write_capacity(logic [3:0] c);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cap_now = c;
        n_cap_write++;
    endtask

    task automatic enq(logic [31:0] e, logic [15:0] p);
        push_request(make_word(MODE_ENQ, e, p));
    endtask

    task automatic deq();
        push_request(make_word(MODE_DEQ, $urandom, 16'($urandom)));
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern is redrawn after a run of random length among
    // always ready, mostly ready, alternating and mostly stalled.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_kind = $urandom_range(3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        stall_phase = ~stall_phase;
        case (stall_kind)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(3) != 0);
            2:       i_out_ready <= stall_phase;
            default: i_out_ready <= ($urandom_range(5) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checking at the rising edge.
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %p", o_out_word);
                errors++;
            end else begin
                want_word = pending_results.pop_front();
                check_field("out_element",  want_word.out_element,  o_out_word.out_element);
                check_field("out_priority", 32'(want_word.out_priority),
                            32'(o_out_word.out_priority));
                check_field("status",       32'(want_word.status),
                            32'(o_out_word.status));
                check_field("occupancy",    32'(want_word.occupancy),
                            32'(o_out_word.occupancy));
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset capacity of 5: empty dequeue, extreme fields, ties keep arrival
    // order, full drop, then drain to empty.
    task automatic test_reset_ordering();
        deq();
        enq(32'h8000_0000, 16'hffff);
        enq(32'h7fff_ffff, 16'h0000);
        enq(32'h0000_0000, 16'd100);
        enq(32'hffff_ffff, 16'd100);
        enq(32'h0000_0005, 16'd100);
        enq(32'h0000_0007, 16'h0000);   // queue full, dropped
        repeat (6) deq();
    endtask

    // Capacity zero: every enqueue is dropped.
    task automatic test_zero_capacity();
        write_capacity(4'd0);
        enq(32'h1234_5678, 16'd1);
        deq();
    endtask

    // Capacity lowered under the live count: entries stay, enqueues report
    // full until the count falls below the new limit.
    task automatic test_capacity_shrink();
        write_capacity(4'd3);
        enq(32'd10, 16'd7);
        enq(32'd11, 16'd7);
        enq(32'd12, 16'd7);
        write_capacity(4'd1);
        enq(32'd13, 16'd0);
        deq();
        deq();
        enq(32'd14, 16'd7);
        deq();
        enq(32'd15, 16'd2);
        deq();
    endtask

    // Phases of random traffic, each with its own capacity and fill bias.
    // Capacities above the slot count and zero come up regularly; entries
    // carry over between phases, so shrinking under the count recurs.
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned phase_len;
        int unsigned enq_pct;
        logic [3:0]  c;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(6))
                0:       c = 4'd0;
                1:       c = 4'd1;
                2:       c = 4'(NUM_SLOTS);
                3:       c = 4'd15;
                default: c = 4'($urandom_range(1, 15));
            endcase
            write_capacity(c);
            phase_len = (c == 0) ? $urandom_range(4, 12) : $urandom_range(40, 160);
            enq_pct   = $urandom_range(20, 80);
            repeat (phase_len) begin
                push_request(random_request(enq_pct));
                sent++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++)
            slots[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_ordering();
        test_zero_capacity();
        test_capacity_shrink();
        test_random_traffic();

        // drain, then let the bench run quiet to catch stray results
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end

        $display("testbench: %0d stored, %0d dropped full, %0d dequeued, %0d on empty",
                 n_stored, n_dropped, n_dequeued, n_empty);
        $display("testbench: %0d capacity writes, %0d mismatches", n_cap_write, errors);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
tb/testbench.sv
